### rtl/core/bcc_pkg.sv
package bcc_pkg;

    // Time and register widths
    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int REG_W         = 16;
    localparam int EV_W          = 2;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd2;

    // Register values after reset, in milliseconds
    localparam logic [REG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [REG_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [REG_W-1:0] WINDOW_RST   = 16'd400;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EV_W-1:0] EV_SINGLE = 2'd1;
    localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EV_W-1:0] EV_LONG   = 2'd3;

    // Stream payload widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // Timing registers as seen by the classifier
    typedef struct packed {
        logic [REG_W-1:0] debounce_time;
        logic [REG_W-1:0] long_press_time;
        logic [REG_W-1:0] double_click_window;
    } t_cfg;

endpackage

### rtl/core/button_click_classifier.sv
// Button click classifier.
// Slave stream: one request per poll of an active-low button, carrying the raw
// pin level and a wrapping millisecond timestamp. Master stream: one result per
// request, carrying the raised event (none, single, double, long press) and the
// debounced pressed state. Results leave in request order.
// Configuration channel: debounce time, long-press time and double-click
// window (index 0, 1, 2), 16-bit milliseconds each; write only while idle.
// A request accepted into the input register is classified as it moves into the
// result register, which happens once that register is free or being emptied.
// Throughput: one request per cycle while the master side keeps tready high, set
// by the classify step that reads and updates the state as the request moves.
// Reset: state returns to released with no click pending, registers return to
// 50 / 1000 / 400 ms, both stream registers empty.
// Stall: when the master side holds tready low the result register holds; the
// input register still takes one more request, then s_axis_tready drops.
module button_click_classifier #(
    parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] raw_level, [32:1] now_ms, [39:33] zero
    input  logic [bcc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] event_res, [2] pressed, [7:3] zero
    output logic [bcc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bcc_pkg::REG_W-1:0]           i_cfg_data
);
    import bcc_pkg::*;

    logic             r_in_valid;
    logic             r_raw;
    logic [NOW_W-1:0] r_now;
    logic             r_out_valid;
    logic [EV_W-1:0]  r_event;
    logic             r_pressed;

    logic             w_move;
    logic [EV_W-1:0]  w_event;
    logic             w_pressed;
    t_cfg             w_cfg;

    // Timing registers
    assign o_cfg_ready = 1'b1;

    bcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // Move the held request into the result register when it is free
    assign w_move        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_move;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_raw <= s_axis_tdata[0];
            r_now <= s_axis_tdata[NOW_W:1];
        end
    end

    // Classifier and button state
    bcc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_move),
        .i_raw     (r_raw),
        .i_now     (r_now),
        .i_cfg     (w_cfg),
        .o_event   (w_event),
        .o_pressed (w_pressed)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_event   <= w_event;
            r_pressed <= w_pressed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - EV_W - 1){1'b0}}, r_pressed, r_event};

    // A classified request always lands in the result register
    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("classified request lost");

    // A held request waits while the result register is blocked
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_move) |=> (r_in_valid && $stable(r_now) && $stable(r_raw)))
        else $error("held request dropped");

endmodule

### rtl/core/bcc_cfg.sv
module bcc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [bcc_pkg::REG_W-1:0]     i_data,
    output bcc_pkg::t_cfg                 o_cfg
);
    import bcc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the register index; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_index)
                CFG_DEBOUNCE: n_cfg.debounce_time       = i_data;
                CFG_LONG:     n_cfg.long_press_time     = i_data;
                CFG_WINDOW:   n_cfg.double_click_window = i_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time       <= DEBOUNCE_RST;
            r_cfg.long_press_time     <= LONG_RST;
            r_cfg.double_click_window <= WINDOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/bcc_core.sv
module bcc_core #(
    parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_raw,
    input  logic [bcc_pkg::NOW_W-1:0] i_now,
    input  bcc_pkg::t_cfg             i_cfg,
    output logic [bcc_pkg::EV_W-1:0]  o_event,
    output logic                      o_pressed
);
    import bcc_pkg::*;

    logic                 r_prev_raw,      n_prev_raw;
    logic [TIME_BITS-1:0] r_change_time,   n_change_time;
    logic                 r_db_level,      n_db_level;
    logic [TIME_BITS-1:0] r_press_start,   n_press_start;
    logic [TIME_BITS-1:0] r_first_click,   n_first_click;
    logic                 r_long_reported, n_long_reported;
    logic                 r_click_pending, n_click_pending;

    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_el_db;
    logic [TIME_BITS-1:0] w_el_press;
    logic [TIME_BITS-1:0] w_el_click;
    logic [EV_W-1:0]      w_event;

    // Reduce the timestamp to the working time width
    assign w_now      = TIME_BITS'(i_now);
    // A level change restarts the debounce timer at this poll
    assign w_el_db    = (i_raw != r_prev_raw) ? '0 : (w_now - r_change_time);
    assign w_el_press = w_now - r_press_start;
    assign w_el_click = w_now - r_first_click;

    // Debounce the pin and classify clicks for the current poll
    always_comb begin
        n_prev_raw      = r_prev_raw;
        n_change_time   = r_change_time;
        n_db_level      = r_db_level;
        n_press_start   = r_press_start;
        n_first_click   = r_first_click;
        n_long_reported = r_long_reported;
        n_click_pending = r_click_pending;
        w_event         = EV_NONE;

        if (i_raw != r_prev_raw) begin
            n_change_time = w_now;
            n_prev_raw    = i_raw;
        end

        if (w_el_db >= TIME_BITS'(i_cfg.debounce_time)) begin
            if (i_raw != r_db_level) begin
                n_db_level = i_raw;
                if (!i_raw) begin
                    n_press_start   = w_now;
                    n_long_reported = 1'b0;
                end else if (!r_long_reported) begin
                    // First release opens the window, second one closes it
                    if (!r_click_pending) begin
                        n_click_pending = 1'b1;
                        n_first_click   = w_now;
                    end else begin
                        n_click_pending = 1'b0;
                        w_event         = EV_DOUBLE;
                    end
                end
            end else begin
                if (!r_db_level && !r_long_reported &&
                    w_el_press >= TIME_BITS'(i_cfg.long_press_time)) begin
                    n_long_reported = 1'b1;
                    n_click_pending = 1'b0;
                    w_event         = EV_LONG;
                end
                // Long press already dropped any pending click
                if (n_click_pending &&
                    w_el_click >= TIME_BITS'(i_cfg.double_click_window)) begin
                    n_click_pending = 1'b0;
                    w_event         = EV_SINGLE;
                end
            end
        end
    end

    // Advance the button state once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw      <= 1'b1;
            r_change_time   <= '0;
            r_db_level      <= 1'b1;
            r_press_start   <= '0;
            r_first_click   <= '0;
            r_long_reported <= 1'b0;
            r_click_pending <= 1'b0;
        end else if (i_en) begin
            r_prev_raw      <= n_prev_raw;
            r_change_time   <= n_change_time;
            r_db_level      <= n_db_level;
            r_press_start   <= n_press_start;
            r_first_click   <= n_first_click;
            r_long_reported <= n_long_reported;
            r_click_pending <= n_click_pending;
        end
    end

    assign o_event   = w_event;
    assign o_pressed = ~n_db_level;

    // A pending click never survives a reported long press
    a_pending_excl_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_click_pending |-> !r_long_reported)
        else $error("click pending while long press reported");

    a_double_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_event == EV_DOUBLE) |=> !r_click_pending)
        else $error("double press left a click pending");

    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_event == EV_LONG) |=> (!r_db_level && r_long_reported))
        else $error("long press raised while not held");

endmodule
